### sv/brms_pkg.sv
// Types, codes and the mode-to-bank mapping for the banked register file.
package brms_pkg;

    localparam int WORD_W    = 32;
    localparam int MODE_W    = 5;
    localparam int IDX_W     = 4;
    localparam int NUM_REGS  = 16;
    localparam int NUM_BANKS = 6;
    localparam int BANK_W    = 3;
    localparam int HI_CNT    = 5;
    localparam int HI_BASE   = 8;
    localparam int REG_SP    = 13;
    localparam int REG_LR    = 14;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [BANK_W-1:0] bank_t;

    typedef enum logic [1:0] {
        REQ_MODE   = 2'd0,
        REQ_READ   = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_STATUS = 2'd3
    } req_kind_t;

    localparam mode_t MODE_USR  = 5'd16;
    localparam mode_t MODE_FAST = 5'd17;
    localparam mode_t MODE_INTR = 5'd18;
    localparam mode_t MODE_SVC  = 5'd19;
    localparam mode_t MODE_ABT  = 5'd23;
    localparam mode_t MODE_UND  = 5'd27;
    localparam mode_t MODE_SYS  = 5'd31;

    localparam bank_t BANK_USR  = 3'd0;
    localparam bank_t BANK_FAST = 3'd1;
    localparam bank_t BANK_INTR = 3'd2;
    localparam bank_t BANK_SVC  = 3'd3;
    localparam bank_t BANK_ABT  = 3'd4;
    localparam bank_t BANK_UND  = 3'd5;

    typedef struct packed {
        logic [1:0] req_type;
        mode_t      new_mode;
        idx_t       reg_index;
        word_t      write_data;
    } req_t;

    typedef struct packed {
        word_t read_data;
        mode_t current_mode;
        word_t saved_status;
    } rsp_t;

    typedef struct packed {
        logic  swap;
        logic  fiq_swap;
        logic  to_fiq;
        bank_t old_bank;
        bank_t new_bank;
    } swap_ctrl_t;

    typedef struct packed {
        word_t                  sp;
        word_t                  lr;
        word_t                  status;
        logic [HI_CNT-1:0][WORD_W-1:0] hi;
    } bank_data_t;

    function automatic bank_t bank_of(input mode_t m);
        bank_t b;
        case (m)
            MODE_FAST: b = BANK_FAST;
            MODE_INTR: b = BANK_INTR;
            MODE_SVC:  b = BANK_SVC;
            MODE_ABT:  b = BANK_ABT;
            MODE_UND:  b = BANK_UND;
            default:   b = BANK_USR;
        endcase
        return b;
    endfunction

endpackage

### sv/brms_req_reg.sv
// Input register: captures one request transaction per cycle.
module brms_req_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  brms_pkg::req_t req_in,
    output logic          valid,
    output brms_pkg::req_t req_out
);
    import brms_pkg::*;

    logic valid_reg;
    req_t req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign valid   = valid_reg;
    assign req_out = req_reg;

endmodule

### sv/brms_bank_store.sv
// Banked SP/LR/status slots per bank and the two r8-r12 sets (normal and FIQ).
module brms_bank_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  brms_pkg::swap_ctrl_t ctrl,
    input  brms_pkg::bank_data_t live,
    output brms_pkg::bank_data_t banked
);
    import brms_pkg::*;

    word_t sp_bank_reg     [NUM_BANKS];
    word_t lr_bank_reg     [NUM_BANKS];
    word_t status_bank_reg [NUM_BANKS];
    logic [HI_CNT-1:0][WORD_W-1:0] hi_usr_reg;
    logic [HI_CNT-1:0][WORD_W-1:0] hi_fiq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                sp_bank_reg[b]     <= '0;
                lr_bank_reg[b]     <= '0;
                status_bank_reg[b] <= '0;
            end
            hi_usr_reg <= '0;
            hi_fiq_reg <= '0;
        end
        else
        begin
            if (ctrl.swap)
            begin
                sp_bank_reg[ctrl.old_bank]     <= live.sp;
                lr_bank_reg[ctrl.old_bank]     <= live.lr;
                status_bank_reg[ctrl.old_bank] <= live.status;
            end
            if (ctrl.fiq_swap)
            begin
                if (ctrl.to_fiq)
                begin
                    hi_usr_reg <= live.hi;
                end
                else
                begin
                    hi_fiq_reg <= live.hi;
                end
            end
        end
    end

    always_comb
    begin
        banked.sp     = sp_bank_reg[ctrl.new_bank];
        banked.lr     = lr_bank_reg[ctrl.new_bank];
        banked.status = status_bank_reg[ctrl.new_bank];
        banked.hi     = ctrl.to_fiq ? hi_fiq_reg : hi_usr_reg;
    end

endmodule

### sv/brms_core.sv
// Live registers, mode and saved status; applies one request and registers the result.
module brms_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    input  brms_pkg::req_t req,
    output logic           done,
    output brms_pkg::rsp_t rsp
);
    import brms_pkg::*;

    word_t gregs_reg  [NUM_REGS];
    word_t gregs_next [NUM_REGS];
    mode_t mode_reg;
    mode_t mode_next;
    word_t status_reg;
    word_t status_next;
    logic  done_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    swap_ctrl_t ctrl;
    bank_data_t live;
    bank_data_t banked;
    logic       mode_chg;

    always_comb
    begin
        mode_chg      = valid && (req.req_type == REQ_MODE) && (req.new_mode != mode_reg);
        ctrl.old_bank = bank_of(mode_reg);
        ctrl.new_bank = bank_of(req.new_mode);
        ctrl.swap     = mode_chg && (ctrl.old_bank != ctrl.new_bank);
        ctrl.fiq_swap = ctrl.swap && ((req.new_mode == MODE_FAST) || (mode_reg == MODE_FAST));
        ctrl.to_fiq   = (ctrl.new_bank == BANK_FAST);

        live.sp     = gregs_reg[REG_SP];
        live.lr     = gregs_reg[REG_LR];
        live.status = status_reg;
        for (int i = 0; i < HI_CNT; i++)
        begin
            live.hi[i] = gregs_reg[HI_BASE + i];
        end
    end

    brms_bank_store u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .live   (live),
        .banked (banked)
    );

    always_comb
    begin
        gregs_next  = gregs_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        if (mode_chg)
        begin
            mode_next = req.new_mode;
        end
        if (ctrl.swap)
        begin
            gregs_next[REG_SP] = banked.sp;
            gregs_next[REG_LR] = banked.lr;
            status_next        = banked.status;
        end
        if (ctrl.fiq_swap)
        begin
            for (int i = 0; i < HI_CNT; i++)
            begin
                gregs_next[HI_BASE + i] = banked.hi[i];
            end
        end
        if (valid && (req.req_type == REQ_WRITE))
        begin
            gregs_next[req.reg_index] = req.write_data;
        end
        if (valid && (req.req_type == REQ_STATUS))
        begin
            status_next = req.write_data;
        end

        rsp_next.read_data    = (req.req_type == REQ_READ) ? gregs_reg[req.reg_index] : '0;
        rsp_next.current_mode = mode_next;
        rsp_next.saved_status = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                gregs_reg[r] <= '0;
            end
            mode_reg   <= MODE_SYS;
            status_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            gregs_reg  <= gregs_next;
            mode_reg   <= mode_next;
            status_reg <= status_next;
            done_reg   <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### sv/banked_register_mode_switch.sv
// Top level: banked register file with processor-mode switching.
//
//   channel   signals            transaction when
//   request   start, busy, req   start && !busy at rising clk
//   result    done, rsp          done high for one cycle
//
// A request is captured in the input register, then applied to the live state
// as the core registers done and the result; busy stays low, so one request
// is taken every cycle. rst_n clears the general registers, banks and
// status, and sets system mode. The receiver cannot stall; every result is
// shown exactly once.
module banked_register_mode_switch (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  brms_pkg::req_t req,
    output logic           done,
    output brms_pkg::rsp_t rsp
);
    import brms_pkg::*;

    logic q_valid;
    req_t q_req;

    assign busy = 1'b0;

    brms_req_reg u_req (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (start && !busy),
        .req_in  (req),
        .valid   (q_valid),
        .req_out (q_req)
    );

    brms_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (q_valid),
        .req   (q_req),
        .done  (done),
        .rsp   (rsp)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without result two cycles later");

    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.read_data != '0)) |-> ($past(q_req.req_type) == REQ_READ))
        else $error("nonzero read data on a non-read transaction");

    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && ($past(q_req.req_type) != REQ_MODE))
        |-> (rsp.current_mode == $past(rsp.current_mode)))
        else $error("mode changed without a mode-change transaction");

endmodule

### test/brms_bank_checker.sv
// Watches request and result transactions, predicts each result and compares it.
module brms_bank_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  brms_pkg::req_t  req,
    input  logic            done,
    input  brms_pkg::rsp_t  rsp,
    output int              errors,
    output int              pending
);
    import brms_pkg::*;

    word_t regs    [NUM_REGS];
    word_t sp_slot [NUM_BANKS];
    word_t lr_slot [NUM_BANKS];
    word_t sr_slot [NUM_BANKS];
    word_t hi_slot [2][HI_CNT];
    word_t live_sr;
    mode_t cur_mode;
    rsp_t  rsp_due [$];

    initial errors = 0;
    initial pending = 0;

    function automatic bank_t mode_bank(input mode_t m);
        bank_t b;
        b = BANK_USR;
        if (m == MODE_FAST) b = BANK_FAST;
        else if (m == MODE_INTR) b = BANK_INTR;
        else if (m == MODE_SVC) b = BANK_SVC;
        else if (m == MODE_ABT) b = BANK_ABT;
        else if (m == MODE_UND) b = BANK_UND;
        return b;
    endfunction

    function automatic void switch_mode(input mode_t m);
        bank_t ob;
        bank_t nb;
        int    of;
        int    nf;
        ob = mode_bank(cur_mode);
        nb = mode_bank(m);
        if (m == cur_mode)
            return;
        if (ob != nb)
        begin
            // r8-r12 bank only between fiq and everything else
            if (ob == BANK_FAST || nb == BANK_FAST)
            begin
                of = (ob == BANK_FAST) ? 1 : 0;
                nf = (nb == BANK_FAST) ? 1 : 0;
                for (int i = 0; i < HI_CNT; i++)
                    hi_slot[of][i] = regs[HI_BASE + i];
                for (int i = 0; i < HI_CNT; i++)
                    regs[HI_BASE + i] = hi_slot[nf][i];
            end
            sp_slot[ob] = regs[REG_SP];
            lr_slot[ob] = regs[REG_LR];
            regs[REG_SP] = sp_slot[nb];
            regs[REG_LR] = lr_slot[nb];
            sr_slot[ob] = live_sr;
            live_sr = sr_slot[nb];
        end
        cur_mode = m;
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        o = '0;
        case (req_kind_t'(r.req_type))
            REQ_MODE:   switch_mode(r.new_mode);
            REQ_READ:   o.read_data = regs[r.reg_index];
            REQ_WRITE:  regs[r.reg_index] = r.write_data;
            REQ_STATUS: live_sr = r.write_data;
            default:    ;
        endcase
        o.current_mode = cur_mode;
        o.saved_status = live_sr;
        return o;
    endfunction

    task automatic check_field(input string name, input word_t want, input word_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            foreach (regs[i]) regs[i] = '0;
            foreach (sp_slot[i])
            begin
                sp_slot[i] = '0;
                lr_slot[i] = '0;
                sr_slot[i] = '0;
            end
            foreach (hi_slot[i, j]) hi_slot[i][j] = '0;
            live_sr = '0;
            cur_mode = MODE_SYS;
            rsp_due.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("read_data", want.read_data, rsp.read_data);
                    check_field("current_mode", word_t'(want.current_mode),
                                word_t'(rsp.current_mode));
                    check_field("saved_status", want.saved_status, rsp.saved_status);
                end
            end
            if (start && !busy)
                rsp_due.push_back(apply_request(req));
            pending = rsp_due.size();
        end
    end

endmodule

### test/tb_banked_register_mode_switch.sv
// Testbench top: clock, reset, directed and random request stimulus, verdict.
module tb_banked_register_mode_switch;
    import brms_pkg::*;

    localparam mode_t KNOWN_MODES [7] = '{MODE_USR, MODE_FAST, MODE_INTR, MODE_SVC,
                                          MODE_ABT, MODE_UND, MODE_SYS};
    localparam int PHASE_ITEMS = 500;
    localparam int IDLE_PCT [4] = '{0, 68, 12, 0};

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   errors;
    int   pending;

    banked_register_mode_switch DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    brms_bank_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic req_t make_req(input req_kind_t kind, input mode_t m,
                                      input idx_t idx, input word_t data);
        req_t r;
        r.req_type   = kind;
        r.new_mode   = m;
        r.reg_index  = idx;
        r.write_data = data;
        return r;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 25) r.req_type = REQ_MODE;
        else if (pick < 55) r.req_type = REQ_READ;
        else if (pick < 85) r.req_type = REQ_WRITE;
        else r.req_type = REQ_STATUS;
        if ($urandom_range(99) < 80)
            r.new_mode = KNOWN_MODES[$urandom_range(6)];
        else
            r.new_mode = mode_t'($urandom_range(31));
        // banked registers r8-r14 get most of the traffic
        if ($urandom_range(99) < 60)
            r.reg_index = idx_t'($urandom_range(14, 8));
        else
            r.reg_index = idx_t'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 10) r.write_data = '0;
        else if (pick < 20) r.write_data = '1;
        else r.write_data = $urandom;
        return r;
    endfunction

    // Called right after a rising edge; returns at the edge that takes the transaction.
    task automatic issue(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            req   <= rand_req();
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int waited;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(make_req(REQ_READ,   MODE_SYS,  4'd13, 32'h0));
        issue(make_req(REQ_WRITE,  5'd0,      4'd13, 32'hFFFF_FFFF));
        issue(make_req(REQ_WRITE,  5'd31,     4'd8,  32'hA5A5_A5A5));
        issue(make_req(REQ_WRITE,  5'd0,      4'd14, 32'h5A5A_5A5A));
        issue(make_req(REQ_STATUS, 5'd31,     4'd15, 32'hFFFF_FFFF));
        issue(make_req(REQ_MODE,   MODE_SYS,  4'd0,  32'hFFFF_FFFF));
        issue(make_req(REQ_MODE,   MODE_USR,  4'd15, 32'h0));
        issue(make_req(REQ_MODE,   MODE_FAST, 4'd0,  32'h0));
        issue(make_req(REQ_READ,   5'd0,      4'd8,  32'hFFFF_FFFF));
        issue(make_req(REQ_WRITE,  5'd0,      4'd8,  32'h1234_5678));
        issue(make_req(REQ_WRITE,  5'd0,      4'd13, 32'h0000_0001));
        issue(make_req(REQ_STATUS, 5'd0,      4'd0,  32'h8000_0011));
        issue(make_req(REQ_MODE,   MODE_INTR, 4'd0,  32'h0));
        issue(make_req(REQ_READ,   5'd0,      4'd8,  32'h0));
        issue(make_req(REQ_READ,   5'd0,      4'd13, 32'h0));
        issue(make_req(REQ_MODE,   5'd5,      4'd0,  32'h0));
        issue(make_req(REQ_READ,   5'd0,      4'd13, 32'h0));
        issue(make_req(REQ_STATUS, 5'd0,      4'd0,  32'h0));
        issue(make_req(REQ_MODE,   MODE_SVC,  4'd0,  32'h0));
        issue(make_req(REQ_MODE,   MODE_ABT,  4'd0,  32'h0));
        issue(make_req(REQ_MODE,   MODE_UND,  4'd0,  32'h0));
        issue(make_req(REQ_WRITE,  5'd0,      4'd15, 32'h0));
        issue(make_req(REQ_MODE,   MODE_FAST, 4'd0,  32'h0));
        issue(make_req(REQ_READ,   5'd0,      4'd8,  32'h0));
        issue(make_req(REQ_MODE,   MODE_SYS,  4'd0,  32'h0));

        for (int p = 0; p < 4; p++)
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                gap(IDLE_PCT[p]);
                issue(rand_req());
            end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
